// ===== src/ntl_pkg.sv =====
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared types, constants and hash helpers for the name hash table.
// ----------------------------------------------------------------------------
package ntl_pkg;

    // table geometry, slot count is a power of two
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_AW     = $clog2(TABLE_SLOTS);

    // payload widths
    localparam int KEY_W   = 64;
    localparam int VALUE_W = 10;

    // fnv-1a 32-bit constants
    localparam logic [31:0] HASH_BASIS = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // nul bytes become spaces
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = k;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (k[8*b +: 8] == 8'h00) begin
                r[8*b +: 8] = 8'h20;
            end
        end
        return r;
    endfunction

    // one fnv-1a round; low bits of the product only depend on low bits
    function automatic logic [SLOT_AW-1:0] fnv_step(input logic [SLOT_AW-1:0] h,
                                                   input logic [7:0] b);
        logic [31:0] t;
        logic [31:0] p;
        t = 32'(h) ^ {24'd0, b};
        p = t * HASH_PRIME;
        return p[SLOT_AW-1:0];
    endfunction

endpackage

// ===== src/ntl_ram.sv =====
// ----------------------------------------------------------------------------
// ntl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ntl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/name_hash_table_linear_probe.sv =====
// ----------------------------------------------------------------------------
// name_hash_table_linear_probe
// Open-addressed table of 8-byte names with linear probing on an fnv-1a
// home slot; insert, find and clear requests give one result each.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                      | content
//  ---------+-----------+------------------------------+------------------------
//  s_       | in        | s_tvalid s_tready s_tdata    | key, index, opcode
//           |           | s_tuser                      |
//  m_       | out       | m_tvalid m_tready m_tdata    | hit, found_index, full
//
//  insert/find: accept, hash the key two bytes per cycle, then read and check
//  each probed slot through the registered memory read and load the result
//  register; clear and reset sweep the valid bits one slot a cycle over all
//  TABLE_SLOTS slots, with s_tready low. A waiting result does not block the
//  next accept; the next result holds in its final state until m_ is free.
// ----------------------------------------------------------------------------
module name_hash_table_linear_probe
    import ntl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key_name[63:0], entry_index[73:64], zero pad
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // hit[0], found_index[10:1], table_full[11], pad
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_HASH  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [SLOT_AW-1:0]  hash_reg, hash_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [SLOT_AW-1:0]  pos_reg, pos_next;
    logic [SLOT_AW-1:0]  probes_reg, probes_next;
    logic [SLOT_AW-1:0]  sweep_reg, sweep_next;
    logic                boot_reg, boot_next;
    logic                res_hit_reg, res_hit_next;
    logic [VALUE_W-1:0]  res_index_reg, res_index_next;
    logic                res_full_reg, res_full_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    logic                wr_en;
    logic [SLOT_AW-1:0]  wr_addr;
    slot_t               wr_slot;
    logic                rd_en;
    logic [SLOT_AW-1:0]  rd_addr;
    logic [SLOT_W-1:0]   rd_data;
    slot_t               rd_slot;
    logic [SLOT_AW-1:0]  hash_two;
    logic [SLOT_AW-1:0]  pos_inc;
    logic                out_free;
    logic                s_accept;

    ntl_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_slot),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign rd_slot  = slot_t'(rd_data);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pos_inc  = pos_reg + 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // two hash rounds per cycle
    assign hash_two = fnv_step(fnv_step(hash_reg, key_reg[{cnt_reg, 4'd0} +: 8]),
                               key_reg[{cnt_reg, 4'd8} +: 8]);

    // sequencer and memory control
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        hash_next      = hash_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        probes_next    = probes_reg;
        sweep_next     = sweep_reg;
        boot_next      = boot_reg;
        res_hit_next   = res_hit_reg;
        res_index_next = res_index_reg;
        res_full_next  = res_full_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_slot        = '0;
        rd_en          = 1'b0;
        rd_addr        = pos_inc;

        // result register drains on the master side
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next        = opcode_t'(s_tuser);
                    key_next       = normalize_key(s_tdata[KEY_W-1:0]);
                    value_next     = s_tdata[KEY_W +: VALUE_W];
                    hash_next      = HASH_BASIS[SLOT_AW-1:0];
                    cnt_next       = 2'd0;
                    sweep_next     = '0;
                    res_hit_next   = 1'b0;
                    res_index_next = '0;
                    res_full_next  = 1'b0;
                    case (opcode_t'(s_tuser))
                        OP_INSERT, OP_FIND: state_next = ST_HASH;
                        OP_CLEAR:           state_next = ST_SWEEP;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end

            ST_HASH: begin
                hash_next = hash_two;
                cnt_next  = cnt_reg + 2'd1;
                // last round issues the read of the home slot
                if (cnt_reg == 2'd3) begin
                    rd_en       = 1'b1;
                    rd_addr     = hash_two;
                    pos_next    = hash_two;
                    probes_next = '0;
                    state_next  = ST_CHECK;
                end
            end

            ST_CHECK: begin
                if (op_reg == OP_INSERT) begin
                    if (!rd_slot.valid) begin
                        // claim the empty slot
                        wr_en         = 1'b1;
                        wr_addr       = pos_reg;
                        wr_slot.valid = 1'b1;
                        wr_slot.key   = key_reg;
                        wr_slot.value = value_reg;
                        res_hit_next  = 1'b1;
                        state_next    = ST_DONE;
                    end else if (probes_reg == '1) begin
                        res_full_next = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        rd_en       = 1'b1;
                        pos_next    = pos_inc;
                        probes_next = probes_reg + 1'b1;
                    end
                end else begin
                    if (!rd_slot.valid) begin
                        state_next = ST_DONE;
                    end else if (rd_slot.key == key_reg) begin
                        res_hit_next   = 1'b1;
                        res_index_next = rd_slot.value;
                        state_next     = ST_DONE;
                    end else if (probes_reg == '1) begin
                        // every slot probed, miss
                        state_next = ST_DONE;
                    end else begin
                        rd_en       = 1'b1;
                        pos_next    = pos_inc;
                        probes_next = probes_reg + 1'b1;
                    end
                end
            end

            ST_SWEEP: begin
                // drop one valid bit per cycle
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_slot    = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                end
            end

            ST_DONE: begin
                // hand the result over once the output register is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, res_full_reg, res_index_reg, res_hit_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            boot_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            boot_reg     <= boot_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        hash_reg      <= hash_next;
        cnt_reg       <= cnt_next;
        pos_reg       <= pos_next;
        probes_reg    <= probes_next;
        res_hit_reg   <= res_hit_next;
        res_index_reg <= res_index_next;
        res_full_reg  <= res_full_next;
        m_tdata_reg   <= m_tdata_next;
    end

endmodule
